[hw/rtl/assert_macros.svh]
// Assertion macros shared by the converter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define C2S_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define C2S_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define C2S_ASSERT(lbl, clk, rst_n, prop, msg)
`define C2S_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[hw/rtl/c2s_pkg.sv]
// Shared constants, types and the arctangent table of the spherical converter.
// No dependencies; imported by every module of the block.
package c2s_pkg;

  localparam int DW          = 64;
  localparam int AW          = 32;
  localparam int COORD_IN_W  = 32;
  localparam int RANGE_W     = 32;
  localparam int ANG_OUT_W   = 16;
  localparam int SCALED_BITS = 54;
  localparam int MAX_STEPS   = 32;
  localparam int ANG_ROUND   = 128;
  localparam int ANG_SHIFT   = 8;
  localparam int THETA_MAX   = 32768;
  localparam int Q_DEPTH     = 4;

  localparam int DEF_CORDIC_STEPS = 18;
  localparam int DEF_COORD_WIDTH  = 32;

  localparam logic signed [AW-1:0] HALF_PI  = AW'(32'sd4194304);
  localparam logic [31:0]          INV_GAIN = 32'h9B74_EDA8;

  typedef struct packed {
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic signed [AW-1:0] ang;
    logic                 skip;
  } vec_in_t;

  typedef struct packed {
    logic [DW-1:0]        mag;
    logic signed [AW-1:0] ang;
  } vec_out_t;

  typedef struct packed {
    logic [DW-1:0]          rxy;
    logic signed [DW-1:0]   z;
    logic [ANG_OUT_W-1:0]   az;
  } q_entry_t;

  // round(atan(2^-i) * 2^23 / pi)
  function automatic logic signed [AW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [AW-1:0] v;
    case (idx)
      5'd0:    v = AW'(32'sd2097152);
      5'd1:    v = AW'(32'sd1238021);
      5'd2:    v = AW'(32'sd654136);
      5'd3:    v = AW'(32'sd332050);
      5'd4:    v = AW'(32'sd166669);
      5'd5:    v = AW'(32'sd83416);
      5'd6:    v = AW'(32'sd41718);
      5'd7:    v = AW'(32'sd20860);
      5'd8:    v = AW'(32'sd10430);
      5'd9:    v = AW'(32'sd5215);
      5'd10:   v = AW'(32'sd2608);
      5'd11:   v = AW'(32'sd1304);
      5'd12:   v = AW'(32'sd652);
      5'd13:   v = AW'(32'sd326);
      5'd14:   v = AW'(32'sd163);
      5'd15:   v = AW'(32'sd81);
      5'd16:   v = AW'(32'sd41);
      5'd17:   v = AW'(32'sd20);
      5'd18:   v = AW'(32'sd10);
      5'd19:   v = AW'(32'sd5);
      5'd20:   v = AW'(32'sd3);
      5'd21:   v = AW'(32'sd1);
      5'd22:   v = AW'(32'sd1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/c2s_vec_pipe.sv]
// Pipelined vectoring CORDIC, one step per stage, followed by gain correction.
// Depends on c2s_pkg; used by both the front and the back of the converter.
module c2s_vec_pipe
  import c2s_pkg::*;
#(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
  parameter int SIDE_W       = ANG_OUT_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  vec_in_t           in_vec,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output vec_out_t          out_vec,
  output logic [SIDE_W-1:0] out_side
);

  localparam int N = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

  logic signed [DW-1:0] x_r    [0:N];
  logic signed [DW-1:0] y_r    [0:N];
  logic signed [AW-1:0] ang_r  [0:N];
  logic                 skip_r [0:N];
  logic [SIDE_W-1:0]    side_r [0:N];
  logic [N:0]           vld_r;

  logic [DW-1:0]        p_hi_r, p_lo_r, p_hi_nxt, p_lo_nxt;
  logic signed [AW-1:0] ga_ang_r;
  logic                 ga_skip_r, ga_vld_r;
  logic [SIDE_W-1:0]    ga_side_r;
  logic [DW-1:0]        mag_r, mag_nxt;
  logic signed [AW-1:0] gb_ang_r;
  logic                 gb_vld_r;
  logic [SIDE_W-1:0]    gb_side_r;
  logic [31:0]          hi, lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      ga_vld_r <= 1'b0;
      gb_vld_r <= 1'b0;
    end else if (en) begin
      vld_r    <= {vld_r[N-1:0], in_valid};
      ga_vld_r <= vld_r[N];
      gb_vld_r <= ga_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= in_vec.a;
      y_r[0]    <= in_vec.b;
      ang_r[0]  <= in_vec.ang;
      skip_r[0] <= in_vec.skip;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic signed [DW-1:0] dx, dy;
    logic signed [AW-1:0] da;
    assign dx = y_r[k] >>> k;
    assign dy = x_r[k] >>> k;
    assign da = atan_lut(5'(k));

    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[k][DW-1]) begin
          x_r[k+1]   <= x_r[k] - dx;
          y_r[k+1]   <= y_r[k] + dy;
          ang_r[k+1] <= ang_r[k] - da;
        end else begin
          x_r[k+1]   <= x_r[k] + dx;
          y_r[k+1]   <= y_r[k] - dy;
          ang_r[k+1] <= ang_r[k] + da;
        end
        skip_r[k+1] <= skip_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign hi       = x_r[N][DW-1:DW/2];
  assign lo       = x_r[N][DW/2-1:0];
  assign p_hi_nxt = DW'(hi) * DW'(INV_GAIN);
  assign p_lo_nxt = DW'(lo) * DW'(INV_GAIN);
  assign mag_nxt  = p_hi_r + ((p_lo_r + (DW'(1) << 31)) >> 32);

  always_ff @(posedge clk) begin
    if (en) begin
      p_hi_r    <= p_hi_nxt;
      p_lo_r    <= p_lo_nxt;
      ga_ang_r  <= ang_r[N];
      ga_skip_r <= skip_r[N];
      ga_side_r <= side_r[N];
      mag_r     <= ga_skip_r ? '0 : mag_nxt;
      gb_ang_r  <= ga_skip_r ? '0 : ga_ang_r;
      gb_side_r <= ga_side_r;
    end
  end

  assign out_valid   = gb_vld_r;
  assign out_vec.mag = mag_r;
  assign out_vec.ang = gb_ang_r;
  assign out_side    = gb_side_r;

endmodule

[hw/rtl/c2s_front.sv]
// Front: takes points, scales and pre-rotates (x, y), runs the azimuth pass.
// Depends on c2s_pkg and c2s_vec_pipe; feeds the queue with r_xy, z, azimuth.
module c2s_front
  import c2s_pkg::*;
#(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
  parameter int COORD_WIDTH  = DEF_COORD_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_IN_W-1:0] x_coord,
  input  logic signed [COORD_IN_W-1:0] y_coord,
  input  logic signed [COORD_IN_W-1:0] z_coord,
  output logic                         out_valid,
  input  logic                         out_ready,
  output q_entry_t                     out_entry
);

  localparam int GUARD = SCALED_BITS - COORD_WIDTH;

  logic signed [DW-1:0] x_ext, y_ext, z_ext, x_s, y_s, z_s;
  logic                 en, p_valid;
  vec_in_t              v_in;
  vec_out_t             v_out;
  logic [DW-1:0]        p_z;
  logic signed [AW-1:0] az_sum;

  if (COORD_WIDTH <= COORD_IN_W) begin : g_sext
    assign x_ext = DW'(signed'(x_coord[COORD_WIDTH-1:0]));
    assign y_ext = DW'(signed'(y_coord[COORD_WIDTH-1:0]));
    assign z_ext = DW'(signed'(z_coord[COORD_WIDTH-1:0]));
  end else begin : g_zext
    assign x_ext = {{(DW-COORD_IN_W){1'b0}}, x_coord};
    assign y_ext = {{(DW-COORD_IN_W){1'b0}}, y_coord};
    assign z_ext = {{(DW-COORD_IN_W){1'b0}}, z_coord};
  end

  assign x_s = x_ext <<< GUARD;
  assign y_s = y_ext <<< GUARD;
  assign z_s = z_ext <<< GUARD;

  // bring (x, y) into the right half-plane
  always_comb begin
    v_in.skip = (x_s == '0) && (y_s == '0);
    if (x_s[DW-1]) begin
      if (!y_s[DW-1]) begin
        v_in.a   = y_s;
        v_in.b   = -x_s;
        v_in.ang = HALF_PI;
      end else begin
        v_in.a   = -y_s;
        v_in.b   = x_s;
        v_in.ang = -HALF_PI;
      end
    end else begin
      v_in.a   = x_s;
      v_in.b   = y_s;
      v_in.ang = '0;
    end
  end

  assign en       = !(p_valid && !out_ready);
  assign in_ready = en;

  c2s_vec_pipe #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .SIDE_W       (DW)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_vec    (v_in),
    .in_side   (z_s),
    .out_valid (p_valid),
    .out_vec   (v_out),
    .out_side  (p_z)
  );

  assign az_sum        = v_out.ang + AW'(ANG_ROUND);
  assign out_valid     = p_valid;
  assign out_entry.rxy = v_out.mag;
  assign out_entry.z   = p_z;
  assign out_entry.az  = az_sum[ANG_SHIFT +: ANG_OUT_W];

endmodule

[hw/rtl/c2s_queue.sv]
// Short FIFO between the azimuth pass and the polar pass.
// Depends on c2s_pkg and assert_macros.svh.
`include "assert_macros.svh"
module c2s_queue
  import c2s_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  q_entry_t in_entry,
  output logic     out_valid,
  input  logic     out_ready,
  output q_entry_t out_entry
);

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  q_entry_t      mem_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop, full, empty;

  assign full      = (count_r == CW'(Q_DEPTH));
  assign empty     = (count_r == '0);
  assign in_ready  = !full;
  assign out_valid = !empty;
  assign push      = in_valid && !full;
  assign pop       = out_ready && !empty;
  assign out_entry = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // pointers wrap naturally, depth is a power of two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_entry;
    end
  end

  `C2S_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(Q_DEPTH), "queue count over depth")
  `C2S_ASSERT(a_push_grows, clk, rst_n, (push && !pop) |=> (count_r == $past(count_r) + 1'b1), "push lost")
  `C2S_ASSERT(a_pop_shrinks, clk, rst_n, (pop && !push) |=> (count_r == $past(count_r) - 1'b1), "pop lost")

endmodule

[hw/rtl/c2s_back.sv]
// Back: runs the polar pass on (z, r_xy), rounds and registers the result.
// Depends on c2s_pkg and c2s_vec_pipe; drains the queue.
module c2s_back
  import c2s_pkg::*;
#(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
  parameter int COORD_WIDTH  = DEF_COORD_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  q_entry_t             in_entry,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [RANGE_W-1:0]   range_out,
  output logic [ANG_OUT_W-1:0] polar_angle,
  output logic [ANG_OUT_W-1:0] azimuth_angle
);

  localparam int GUARD = SCALED_BITS - COORD_WIDTH;

  logic                 en, p_valid;
  logic signed [DW-1:0] rxy_s;
  vec_in_t              v_in;
  vec_out_t             v_out;
  logic [ANG_OUT_W-1:0] p_az;
  logic [DW-1:0]        rng_sum, rng_sh;
  logic [RANGE_W-1:0]   rng;
  logic signed [AW-1:0] th_pos, th_rnd;
  logic [ANG_OUT_W-1:0] th;

  logic                 out_vld_r;
  logic [RANGE_W-1:0]   range_r;
  logic [ANG_OUT_W-1:0] polar_r, az_r;

  assign rxy_s = signed'(in_entry.rxy);

  always_comb begin
    v_in.skip = (in_entry.z == '0) && (in_entry.rxy == '0);
    if (in_entry.z[DW-1]) begin
      v_in.a   = rxy_s;
      v_in.b   = -in_entry.z;
      v_in.ang = HALF_PI;
    end else begin
      v_in.a   = in_entry.z;
      v_in.b   = rxy_s;
      v_in.ang = '0;
    end
  end

  assign en       = !out_vld_r || out_ready;
  assign in_ready = en;

  c2s_vec_pipe #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .SIDE_W       (ANG_OUT_W)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_vec    (v_in),
    .in_side   (in_entry.az),
    .out_valid (p_valid),
    .out_vec   (v_out),
    .out_side  (p_az)
  );

  // round half up, saturate range, clamp theta to 0..pi
  always_comb begin
    rng_sum = v_out.mag + (DW'(1) << (GUARD - 1));
    rng_sh  = rng_sum >> GUARD;
    rng     = (|rng_sh[DW-1:RANGE_W]) ? '1 : rng_sh[RANGE_W-1:0];
    th_pos  = v_out.ang[AW-1] ? '0 : v_out.ang;
    th_rnd  = (th_pos + AW'(ANG_ROUND)) >>> ANG_SHIFT;
    th      = (th_rnd > AW'(THETA_MAX)) ? ANG_OUT_W'(THETA_MAX) : th_rnd[ANG_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      range_r <= rng;
      polar_r <= th;
      az_r    <= p_az;
    end
  end

  assign out_valid     = out_vld_r;
  assign range_out     = range_r;
  assign polar_angle   = polar_r;
  assign azimuth_angle = az_r;

endmodule

[hw/rtl/cartesian_to_spherical.sv]
// Top level of the Cartesian to spherical converter for lidar points.
// Depends on c2s_pkg, c2s_front, c2s_queue and c2s_back.
//
// Usage:
//   in_*  : one point per transfer, x/y/z signed, units of 2^-16 m.
//   out_* : one result per point, in order: range (2^-16 m), polar angle
//           0..32768 and azimuth -32768..32767 (both in units of pi/32768).
//   Throughput: one point per clock while out_tready stays high. Each CORDIC step is its own pipeline
//   stage, so both vectoring passes and both gain multipliers are busy on
//   different points in the same cycle.
//   Path: from input transfer to output valid a point passes the input
//   register, S step stages and two gain stages of the azimuth pass, the
//   queue, the same registers of the polar pass and one output register,
//   where S = min(CORDIC_STEPS, 32).
//   Reset: rst_n low for one clock empties every pipeline and the queue; no
//   clearing pass, the block takes points on the first cycle after reset.
//   Stall: a held output stops the back pass; the front pass keeps running
//   until the four-entry queue fills, then in_tready drops.
module cartesian_to_spherical
  import c2s_pkg::*;
#(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
  parameter int COORD_WIDTH  = DEF_COORD_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // x_coord[31:0], y_coord[63:32], z_coord[95:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // range_out[31:0], polar_angle[47:32], azimuth_angle[63:48]
);

  q_entry_t             f_entry, b_entry;
  logic                 f_valid, f_ready, b_valid, b_ready;
  logic [RANGE_W-1:0]   range_out;
  logic [ANG_OUT_W-1:0] polar_angle, azimuth_angle;

  c2s_front #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .x_coord   (in_tdata[31:0]),
    .y_coord   (in_tdata[63:32]),
    .z_coord   (in_tdata[95:64]),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_entry (f_entry)
  );

  c2s_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_entry  (f_entry),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_entry (b_entry)
  );

  c2s_back #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (b_valid),
    .in_ready      (b_ready),
    .in_entry      (b_entry),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .range_out     (range_out),
    .polar_angle   (polar_angle),
    .azimuth_angle (azimuth_angle)
  );

  assign out_tdata = {azimuth_angle, polar_angle, range_out};

endmodule
